// File: hdl/ed_pkg.sv
// ----------------------------------------------------------------------------
// ed_pkg: shared types and constants for the edit distance block
// Sizes of the cell chain, item opcodes, the wavefront link between cells
// and the control states of the top level.
// ----------------------------------------------------------------------------
package ed_pkg;

    // Longest string held; one cell per first-string character
    localparam int MAX_LEN = 64;
    // Count wide enough to hold MAX_LEN itself
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    // Cell index
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CH_W    = 8;
    localparam int OP_W    = 2;
    localparam int DIST_W  = 7;

    // Item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STREAM = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // Wavefront handed from one cell to the next
    typedef struct packed {
        logic             vld;
        logic [CH_W-1:0]  ch;
        logic [CNT_W-1:0] left;   // new cost of the left neighbor
        logic [CNT_W-1:0] diag;   // old cost of the left neighbor
    } ed_wave_t;

    // Top-level control
    typedef enum logic {
        ST_ACTIVE,
        ST_DRAIN
    } ed_state_t;

endpackage

// File: hdl/ed_cell.sv
// ----------------------------------------------------------------------------
// ed_cell: one column of the dynamic programming row
// Holds one first-string character and its cost entry; updates the entry as
// each second-string character passes and hands the wavefront to the right.
// ----------------------------------------------------------------------------
module ed_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ed_pkg::ed_wave_t         wave_in,
    output ed_pkg::ed_wave_t         wave_out,
    input  logic                     load_en,
    input  logic [ed_pkg::CH_W-1:0]  load_ch,
    input  logic [ed_pkg::CNT_W-1:0] load_cost,
    output logic [ed_pkg::CNT_W-1:0] cost
);
    import ed_pkg::*;

    logic [CH_W-1:0]  char_reg;
    logic [CNT_W-1:0] cost_reg;
    logic [CNT_W-1:0] cost_next;
    logic [CNT_W-1:0] up_inc;
    logic [CNT_W-1:0] left_inc;
    logic [CNT_W-1:0] sub_cost;
    logic [CNT_W-1:0] min_a;
    logic             wave_vld_reg;
    ed_wave_t         wave_pay_reg;

    // Evaluate the recurrence for this column
    always_comb
    begin
        up_inc   = cost_reg + CNT_W'(1);
        left_inc = wave_in.left + CNT_W'(1);
        sub_cost = wave_in.diag + CNT_W'(char_reg != wave_in.ch);
        min_a    = (up_inc < left_inc) ? up_inc : left_inc;
        if (load_en)
            cost_next = load_cost;
        else if (wave_in.vld)
            cost_next = (min_a < sub_cost) ? min_a : sub_cost;
        else
            cost_next = cost_reg;
    end

    // Hold the character and the cost entry
    always_ff @(posedge clk)
    begin
        if (load_en)
            char_reg <= load_ch;
        cost_reg <= cost_next;
    end

    // Advance the wavefront valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_vld_reg <= 1'b0;
        else
            wave_vld_reg <= wave_in.vld;
    end

    // Advance the wavefront payload: new cost to the right, old cost as diagonal
    always_ff @(posedge clk)
    begin
        if (wave_in.vld)
        begin
            wave_pay_reg.vld  <= 1'b1;
            wave_pay_reg.ch   <= wave_in.ch;
            wave_pay_reg.left <= cost_next;
            wave_pay_reg.diag <= cost_reg;
        end
    end

    always_comb
    begin
        wave_out     = wave_pay_reg;
        wave_out.vld = wave_vld_reg;
    end

    assign cost = cost_reg;

endmodule

// File: hdl/edit_distance.sv
// ----------------------------------------------------------------------------
// edit_distance: Levenshtein distance between two byte strings
// A systolic chain of cells, one per first-string character, updates the
// cost row as second-string characters stream through it.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------
//   in      | in_valid / in_ready  | op[1:0], ch[7:0]
//   out     | out_valid / out_ready| distance[6:0], overflow
//
// Load, stream and unused items are taken back to back while the block is
// active; each streamed character enters the chain in the cycle it is taken.
// A finish item waits for the last wavefront to leave the chain and for the
// output register to be free, then registers the result. Input stalls while
// a finish beat waits; a stalled result holds in the output register. Reset
// leaves the block empty.
// ----------------------------------------------------------------------------
module edit_distance (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ed_pkg::OP_W-1:0]   op,
    input  logic [ed_pkg::CH_W-1:0]   ch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ed_pkg::DIST_W-1:0] distance,
    output logic                      overflow
);
    import ed_pkg::*;

    ed_state_t         state_reg;
    ed_state_t         state_next;
    logic [CNT_W-1:0]  first_count_reg;
    logic [CNT_W-1:0]  first_count_next;
    logic [CNT_W-1:0]  second_count_reg;
    logic [CNT_W-1:0]  second_count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic              out_valid_reg;
    logic [DIST_W-1:0] distance_reg;
    logic              overflow_reg;

    logic              in_fire;
    logic              finish_go;
    logic              load_hit;
    logic              busy;
    logic [IDX_W-1:0]  load_idx;
    logic [IDX_W-1:0]  res_idx;
    logic [CNT_W-1:0]  result;
    ed_wave_t          head_wave;

    ed_wave_t          wave [MAX_LEN+1];
    logic [CNT_W-1:0]  cost_row [MAX_LEN];
    logic [MAX_LEN-1:0] wave_vld;

    assign in_fire = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACTIVE:
                if (in_fire && op == OP_FINISH)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (finish_go)
                    state_next = ST_ACTIVE;
            default:
                state_next = ST_ACTIVE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready  = 1'b0;
        finish_go = 1'b0;
        case (state_reg)
            ST_ACTIVE:
                in_ready = 1'b1;
            ST_DRAIN:
                finish_go = !busy && (!out_valid_reg || out_ready);
            default:
                in_ready = 1'b0;
        endcase
    end

    // Decode items into counts, loads and chain injections
    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        load_hit          = 1'b0;
        head_wave.vld     = 1'b0;
        head_wave.ch      = ch;
        head_wave.left    = second_count_reg + CNT_W'(1);
        head_wave.diag    = second_count_reg;
        if (in_fire)
        begin
            case (op)
                OP_LOAD:
                    if (second_count_reg == '0)
                    begin
                        if (first_count_reg >= CNT_W'(MAX_LEN))
                            dropped_next = 1'b1;
                        else
                        begin
                            load_hit         = 1'b1;
                            first_count_next = first_count_reg + CNT_W'(1);
                        end
                    end
                OP_STREAM:
                    if (second_count_reg >= CNT_W'(MAX_LEN))
                        dropped_next = 1'b1;
                    else
                    begin
                        head_wave.vld     = 1'b1;
                        second_count_next = second_count_reg + CNT_W'(1);
                    end
                default:
                    ;
            endcase
        end
        if (finish_go)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            dropped_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ACTIVE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
        end
    end

    // Build the cell chain
    assign load_idx = first_count_reg[IDX_W-1:0];
    assign wave[0]  = head_wave;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        ed_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wave_in   (wave[i]),
            .wave_out  (wave[i+1]),
            .load_en   (load_hit && load_idx == IDX_W'(i)),
            .load_ch   (ch),
            .load_cost (CNT_W'(i + 1)),
            .cost      (cost_row[i])
        );
        assign wave_vld[i] = wave[i+1].vld;
    end

    assign busy = |wave_vld;

    // Pick the final cost entry; an empty first string gives the second length
    assign res_idx = IDX_W'(first_count_reg - CNT_W'(1));
    assign result  = (first_count_reg == '0) ? second_count_reg : cost_row[res_idx];

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_go)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            distance_reg <= DIST_W'(result);
            overflow_reg <= dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign overflow  = overflow_reg;

endmodule
